// ----- rtl/core/clcd_pkg.sv -----
package clcd_pkg;

    // Request type codes on the input side.
    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_COMMAND = 3'd1;
    localparam logic [2:0] REQ_DATA    = 3'd2;
    localparam logic [2:0] REQ_CLEAR   = 3'd3;
    localparam logic [2:0] REQ_HOME    = 3'd4;
    localparam logic [2:0] REQ_CURSOR  = 3'd5;

    // Configuration register indexes.
    localparam int          CFG_INDEX_W = 3;
    localparam int          CFG_DATA_W  = 16;
    localparam logic [2:0]  REG_ENABLE_TICKS     = 3'd0;
    localparam logic [2:0]  REG_DATA_WAIT        = 3'd1;
    localparam logic [2:0]  REG_COMMAND_WAIT     = 3'd2;
    localparam logic [2:0]  REG_CLEAR_WAIT       = 3'd3;
    localparam logic [2:0]  REG_POWER_UP_WAIT    = 3'd4;
    localparam logic [2:0]  REG_RESET_LONG_WAIT  = 3'd5;
    localparam logic [2:0]  REG_RESET_SHORT_WAIT = 3'd6;

    // Register reset values.
    localparam logic [15:0] RST_ENABLE_TICKS     = 16'd20;
    localparam logic [15:0] RST_DATA_WAIT        = 16'd50;
    localparam logic [15:0] RST_COMMAND_WAIT     = 16'd50;
    localparam logic [15:0] RST_CLEAR_WAIT       = 16'd2000;
    localparam logic [15:0] RST_POWER_UP_WAIT    = 16'd15000;
    localparam logic [15:0] RST_RESET_LONG_WAIT  = 16'd5000;
    localparam logic [15:0] RST_RESET_SHORT_WAIT = 16'd1000;

    // Display controller commands and nibbles.
    localparam logic [7:0] CMD_SET_DDRAM     = 8'h80;
    localparam logic [7:0] CMD_FUNCTION_SET  = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON    = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE    = 8'h06;
    localparam logic [7:0] CMD_CLEAR         = 8'h01;
    localparam logic [7:0] CMD_HOME          = 8'h02;
    localparam logic [3:0] NIBBLE_SOFT_RESET = 4'h3;
    localparam logic [3:0] NIBBLE_FOUR_BIT   = 4'h2;

    localparam logic [7:0] LINE_BASE_0 = 8'h00;
    localparam logic [7:0] LINE_BASE_1 = 8'h40;
    localparam logic [7:0] LINE_BASE_2 = 8'h10;
    localparam logic [7:0] LINE_BASE_3 = 8'h50;

    // Default depth of the request queue and of the result queue.
    localparam int QUEUE_DEPTH = 2;

    // A request after classification by the front end.
    typedef struct packed {
        logic       is_req;
        logic       send;
        logic [7:0] byte_val;
        logic       rs;
        logic       extra;
    } req_t;

    // One result beat.
    typedef struct packed {
        logic       rs;
        logic       enable;
        logic [3:0] data;
        logic       busy;
        logic       accepted;
    } res_t;

    typedef struct packed {
        logic                   write;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

    function automatic logic [7:0] line_base(input logic [1:0] row);
        logic [7:0] base;
        unique case (row)
            2'd0: base = LINE_BASE_0;
            2'd1: base = LINE_BASE_1;
            2'd2: base = LINE_BASE_2;
            2'd3: base = LINE_BASE_3;
        endcase
        return base;
    endfunction

endpackage

// ----- rtl/core/clcd_fifo.sv -----
module clcd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/clcd_front.sv -----
module clcd_front #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [2:0]    req_type,
    input  logic [7:0]    byte_value,
    input  logic [6:0]    column,
    input  logic [2:0]    row,
    output logic          req_valid,
    input  logic          req_take,
    output clcd_pkg::req_t req
);
    import clcd_pkg::*;

    req_t req_in;
    logic req_empty;

    // Decode the request into the byte to send and how it is sent.
    always_comb
    begin
        req_in.is_req   = 1'b1;
        req_in.send     = 1'b1;
        req_in.byte_val = byte_value;
        req_in.rs       = 1'b0;
        req_in.extra    = 1'b0;
        unique case (req_type)
            REQ_COMMAND: ;
            REQ_DATA:    req_in.rs = 1'b1;
            REQ_CLEAR:
            begin
                req_in.byte_val = CMD_CLEAR;
                req_in.extra    = 1'b1;
            end
            REQ_HOME:
            begin
                req_in.byte_val = CMD_HOME;
                req_in.extra    = 1'b1;
            end
            REQ_CURSOR:
            begin
                // A row past the fourth line is taken but sends nothing.
                req_in.send     = !row[2];
                req_in.byte_val = CMD_SET_DDRAM + line_base(row[1:0]) + {1'b0, column};
            end
            default:
            begin
                req_in.is_req = 1'b0;
                req_in.send   = 1'b0;
            end
        endcase
    end

    clcd_fifo #(
        .WIDTH($bits(req_t)),
        .DEPTH(DEPTH)
    ) u_req_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .din  (req_in),
        .full (full),
        .pop  (req_take),
        .dout (req),
        .empty(req_empty)
    );

    assign req_valid = !req_empty;

endmodule

// ----- rtl/core/clcd_back.sv -----
module clcd_back #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_take,
    input  clcd_pkg::req_t   req,
    input  clcd_pkg::cfg_wr_t cfg_wr,
    input  logic             pop,
    output logic             empty,
    output clcd_pkg::res_t   res
);
    import clcd_pkg::*;

    localparam logic [4:0] S_START  = 5'd0;
    localparam logic [4:0] S_BOOT   = 5'd1;
    localparam logic [4:0] S_R1P    = 5'd2;
    localparam logic [4:0] S_R1W    = 5'd3;
    localparam logic [4:0] S_R2P    = 5'd4;
    localparam logic [4:0] S_R2W    = 5'd5;
    localparam logic [4:0] S_R3P    = 5'd6;
    localparam logic [4:0] S_R3W    = 5'd7;
    localparam logic [4:0] S_FP     = 5'd8;
    localparam logic [4:0] S_FW     = 5'd9;
    localparam logic [4:0] S_IPULSE = 5'd10;
    localparam logic [4:0] S_IGAP   = 5'd11;
    localparam logic [4:0] S_IWAIT  = 5'd12;
    localparam logic [4:0] S_RPULSE = 5'd13;
    localparam logic [4:0] S_RGAP   = 5'd14;
    localparam logic [4:0] S_RWAIT  = 5'd15;
    localparam logic [4:0] S_IDLE   = 5'd16;

    // Zero-length waits chain phases within one tick; at most three advances
    // are ever needed before a phase with a nonzero count is reached.
    localparam int MAX_ADVANCE = 3;

    typedef struct packed {
        logic [15:0] enable_ticks;
        logic [15:0] data_wait;
        logic [15:0] command_wait;
        logic [15:0] clear_wait;
        logic [15:0] power_up_wait;
        logic [15:0] reset_long_wait;
        logic [15:0] reset_short_wait;
    } cfg_t;

    typedef struct packed {
        logic [4:0]  step;
        logic [15:0] wait_cnt;
        logic [7:0]  held;
        logic        low_next;
        logic        extra;
        logic        rs;
        logic        en;
        logic [3:0]  nib;
    } seq_state_t;

    cfg_t       cfg_reg, cfg_next;
    seq_state_t seq_reg, seq_next;
    seq_state_t cur;
    res_t       res_in;
    logic       res_full;

    function automatic seq_state_t enter_pulse(input seq_state_t s, input logic [4:0] step,
                                               input cfg_t c);
        seq_state_t r;
        r          = s;
        r.step     = step;
        r.en       = 1'b1;
        r.wait_cnt = (c.enable_ticks == 16'd0) ? 16'd1 : c.enable_ticks;
        return r;
    endfunction

    function automatic seq_state_t enter_wait(input seq_state_t s, input logic [4:0] step,
                                              input logic [15:0] n);
        seq_state_t r;
        r          = s;
        r.step     = step;
        r.en       = 1'b0;
        r.wait_cnt = n;
        return r;
    endfunction

    function automatic seq_state_t start_byte(input seq_state_t s, input logic [4:0] step,
                                              input logic [7:0] b, input logic rs,
                                              input logic extra, input cfg_t c);
        seq_state_t r;
        r          = s;
        r.held     = b;
        r.rs       = rs;
        r.extra    = extra;
        r.nib      = b[7:4];
        r.low_next = 1'b1;
        return enter_pulse(r, step, c);
    endfunction

    function automatic seq_state_t advance(input seq_state_t s, input cfg_t c);
        seq_state_t r;
        r = s;
        unique case (s.step)
            S_START: r = enter_wait(s, S_BOOT, c.power_up_wait);
            S_BOOT:
            begin
                r.nib = NIBBLE_SOFT_RESET;
                r.rs  = 1'b0;
                r     = enter_pulse(r, S_R1P, c);
            end
            S_R1P:   r = enter_wait(s, S_R1W, c.reset_long_wait);
            S_R1W:   r = enter_pulse(s, S_R2P, c);
            S_R2P:   r = enter_wait(s, S_R2W, c.reset_short_wait);
            S_R2W:   r = enter_pulse(s, S_R3P, c);
            S_R3P:   r = enter_wait(s, S_R3W, c.reset_short_wait);
            S_R3W:
            begin
                r.nib = NIBBLE_FOUR_BIT;
                r     = enter_pulse(r, S_FP, c);
            end
            S_FP:    r = enter_wait(s, S_FW, c.reset_long_wait);
            S_FW:    r = start_byte(s, S_IPULSE, CMD_FUNCTION_SET, 1'b0, 1'b0, c);
            S_IPULSE, S_RPULSE:
            begin
                if (s.low_next)
                begin
                    // The low nibble is driven during the one-tick gap.
                    r.low_next = 1'b0;
                    r.nib      = s.held[3:0];
                    r          = enter_wait(r, s.step + 5'd1, 16'd1);
                end
                else
                begin
                    r = enter_wait(s, s.step + 5'd2, s.rs ? c.data_wait : c.command_wait);
                end
            end
            S_IGAP:  r = enter_pulse(s, S_IPULSE, c);
            S_RGAP:  r = enter_pulse(s, S_RPULSE, c);
            S_IWAIT:
            begin
                if (s.extra)
                begin
                    r.extra    = 1'b0;
                    r.wait_cnt = c.clear_wait;
                end
                else if (s.held == CMD_FUNCTION_SET)
                begin
                    r = start_byte(s, S_IPULSE, CMD_DISPLAY_ON, 1'b0, 1'b0, c);
                end
                else if (s.held == CMD_DISPLAY_ON)
                begin
                    r = start_byte(s, S_IPULSE, CMD_ENTRY_MODE, 1'b0, 1'b0, c);
                end
                else if (s.held == CMD_ENTRY_MODE)
                begin
                    r = start_byte(s, S_IPULSE, CMD_CLEAR, 1'b0, 1'b1, c);
                end
                else
                begin
                    r.step = S_IDLE;
                end
            end
            S_RWAIT:
            begin
                if (s.extra)
                begin
                    r.extra    = 1'b0;
                    r.wait_cnt = c.clear_wait;
                end
                else
                begin
                    r.step = S_IDLE;
                end
            end
            default:
            begin
                r.step = S_IDLE;
                r.en   = 1'b0;
            end
        endcase
        return r;
    endfunction

    assign req_take = req_valid && !res_full;

    // One tick of the sequencer per request beat.
    always_comb
    begin
        cur = seq_reg;
        for (int i = 0; i < MAX_ADVANCE; i++)
        begin
            if (cur.step != S_IDLE && cur.wait_cnt == 16'd0)
            begin
                cur = advance(cur, cfg_reg);
            end
        end

        res_in.accepted = 1'b0;
        if (cur.step == S_IDLE && req.is_req)
        begin
            res_in.accepted = 1'b1;
            if (req.send)
            begin
                cur = start_byte(cur, S_RPULSE, req.byte_val, req.rs, req.extra, cfg_reg);
            end
        end

        if (cur.step != S_IDLE && cur.wait_cnt != 16'd0)
        begin
            cur.wait_cnt = cur.wait_cnt - 16'd1;
        end

        res_in.rs     = cur.rs;
        res_in.enable = cur.en;
        res_in.data   = cur.nib;
        res_in.busy   = (cur.step != S_IDLE);

        seq_next = req_take ? cur : seq_reg;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr.write)
        begin
            unique case (cfg_wr.index)
                REG_ENABLE_TICKS:     cfg_next.enable_ticks     = cfg_wr.data;
                REG_DATA_WAIT:        cfg_next.data_wait        = cfg_wr.data;
                REG_COMMAND_WAIT:     cfg_next.command_wait     = cfg_wr.data;
                REG_CLEAR_WAIT:       cfg_next.clear_wait       = cfg_wr.data;
                REG_POWER_UP_WAIT:    cfg_next.power_up_wait    = cfg_wr.data;
                REG_RESET_LONG_WAIT:  cfg_next.reset_long_wait  = cfg_wr.data;
                REG_RESET_SHORT_WAIT: cfg_next.reset_short_wait = cfg_wr.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_ticks     <= RST_ENABLE_TICKS;
            cfg_reg.data_wait        <= RST_DATA_WAIT;
            cfg_reg.command_wait     <= RST_COMMAND_WAIT;
            cfg_reg.clear_wait       <= RST_CLEAR_WAIT;
            cfg_reg.power_up_wait    <= RST_POWER_UP_WAIT;
            cfg_reg.reset_long_wait  <= RST_RESET_LONG_WAIT;
            cfg_reg.reset_short_wait <= RST_RESET_SHORT_WAIT;
            seq_reg.step             <= S_START;
            seq_reg.wait_cnt         <= '0;
            seq_reg.held             <= '0;
            seq_reg.low_next         <= 1'b0;
            seq_reg.extra            <= 1'b0;
            seq_reg.rs               <= 1'b0;
            seq_reg.en               <= 1'b0;
            seq_reg.nib              <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            seq_reg <= seq_next;
        end
    end

    clcd_fifo #(
        .WIDTH($bits(res_t)),
        .DEPTH(DEPTH)
    ) u_res_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (req_take),
        .din  (res_in),
        .full (res_full),
        .pop  (pop),
        .dout (res),
        .empty(empty)
    );

endmodule

// ----- rtl/core/char_lcd_4bit_interface_core.sv -----
// A beat flows through the request queue and the result queue. Throughput: one beat per
// cycle while the result queue has room; each beat is one microsecond tick of the
// sequencer, whose zero-length waits chain up to three phase changes within that tick.
// Reset (asynchronous, active low) empties both queues, loads the register defaults and
// starts the power-up script at its first step.
module char_lcd_4bit_interface_core #(
    parameter int QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [2:0]                       req_type,
    input  logic [7:0]                       byte_value,
    input  logic [6:0]                       column,
    input  logic [2:0]                       row,
    input  logic                             pop,
    output logic                             empty,
    output logic                             pin_rs,
    output logic                             pin_enable,
    output logic [3:0]                       pin_data,
    output logic                             busy_res,
    output logic                             accepted,
    input  logic                             cfg_write,
    input  logic [clcd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import clcd_pkg::*;

    req_t    req;
    res_t    res;
    cfg_wr_t cfg_wr;
    logic    req_valid;
    logic    req_take;

    assign cfg_wr.write = cfg_write;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    clcd_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .byte_value(byte_value),
        .column    (column),
        .row       (row),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req       (req)
    );

    clcd_back #(
        .DEPTH(QUEUE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_take (req_take),
        .req      (req),
        .cfg_wr   (cfg_wr),
        .pop      (pop),
        .empty    (empty),
        .res      (res)
    );

    assign pin_rs     = res.rs;
    assign pin_enable = res.enable;
    assign pin_data   = res.data;
    assign busy_res   = res.busy;
    assign accepted   = res.accepted;

endmodule

// ----- sim/lcd_pin_checker.sv -----
`timescale 1ns / 1ps

module lcd_pin_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic                             full,
    input  logic [2:0]                       req_type,
    input  logic [7:0]                       byte_value,
    input  logic [6:0]                       column,
    input  logic [2:0]                       row,
    input  logic                             pop,
    input  logic                             empty,
    input  logic                             pin_rs,
    input  logic                             pin_enable,
    input  logic [3:0]                       pin_data,
    input  logic                             busy_res,
    input  logic                             accepted,
    input  logic                             cfg_write,
    input  logic [clcd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatch_count,
    output int                               pending_beats,
    output logic                             busy_hint
);
    import clcd_pkg::*;

    typedef enum logic [4:0] {
        ST_START,
        ST_BOOT,
        ST_R1_PULSE,
        ST_R1_WAIT,
        ST_R2_PULSE,
        ST_R2_WAIT,
        ST_R3_PULSE,
        ST_R3_WAIT,
        ST_FOUR_PULSE,
        ST_FOUR_WAIT,
        ST_INIT_PULSE,
        ST_INIT_GAP,
        ST_INIT_WAIT,
        ST_REQ_PULSE,
        ST_REQ_GAP,
        ST_REQ_WAIT,
        ST_IDLE
    } seq_e;

    logic [15:0] lcd_regs [0:6];
    seq_e        seq_now;
    logic [15:0] wait_left;
    logic [7:0]  byte_held;
    logic        low_next;
    logic        extra_pending;
    logic        rs_q;
    logic        en_q;
    logic [3:0]  nib_q;

    res_t expected_pins [$];
    int   errors;

    function automatic void load_pulse(input seq_e s);
        seq_now = s;
        en_q = 1'b1;
        // A zero enable width still gives a pulse of one tick.
        wait_left = (lcd_regs[REG_ENABLE_TICKS] == 16'd0) ? 16'd1
                                                          : lcd_regs[REG_ENABLE_TICKS];
    endfunction

    function automatic void load_wait(input seq_e s, input logic [15:0] n);
        seq_now = s;
        en_q = 1'b0;
        wait_left = n;
    endfunction

    function automatic void load_byte(input seq_e s, input logic [7:0] b, input logic rs,
                                      input logic extra);
        byte_held = b;
        rs_q = rs;
        extra_pending = extra;
        nib_q = b[7:4];
        low_next = 1'b1;
        load_pulse(s);
    endfunction

    function automatic void nibble_done();
        seq_e gap_step;
        seq_e wait_step;
        gap_step = (seq_now == ST_INIT_PULSE) ? ST_INIT_GAP : ST_REQ_GAP;
        wait_step = (seq_now == ST_INIT_PULSE) ? ST_INIT_WAIT : ST_REQ_WAIT;
        if (low_next)
        begin
            // The low nibble is already on the bus during the one-tick gap.
            low_next = 1'b0;
            nib_q = byte_held[3:0];
            load_wait(gap_step, 16'd1);
        end
        else
        begin
            load_wait(wait_step, rs_q ? lcd_regs[REG_DATA_WAIT] : lcd_regs[REG_COMMAND_WAIT]);
        end
    endfunction

    function automatic void advance_seq();
        case (seq_now)
            ST_START:      load_wait(ST_BOOT, lcd_regs[REG_POWER_UP_WAIT]);
            ST_BOOT:
            begin
                nib_q = NIBBLE_SOFT_RESET;
                rs_q = 1'b0;
                load_pulse(ST_R1_PULSE);
            end
            ST_R1_PULSE:   load_wait(ST_R1_WAIT, lcd_regs[REG_RESET_LONG_WAIT]);
            ST_R1_WAIT:    load_pulse(ST_R2_PULSE);
            ST_R2_PULSE:   load_wait(ST_R2_WAIT, lcd_regs[REG_RESET_SHORT_WAIT]);
            ST_R2_WAIT:    load_pulse(ST_R3_PULSE);
            ST_R3_PULSE:   load_wait(ST_R3_WAIT, lcd_regs[REG_RESET_SHORT_WAIT]);
            ST_R3_WAIT:
            begin
                nib_q = NIBBLE_FOUR_BIT;
                load_pulse(ST_FOUR_PULSE);
            end
            ST_FOUR_PULSE: load_wait(ST_FOUR_WAIT, lcd_regs[REG_RESET_LONG_WAIT]);
            ST_FOUR_WAIT:  load_byte(ST_INIT_PULSE, CMD_FUNCTION_SET, 1'b0, 1'b0);
            ST_INIT_PULSE: nibble_done();
            ST_REQ_PULSE:  nibble_done();
            ST_INIT_GAP:   load_pulse(ST_INIT_PULSE);
            ST_REQ_GAP:    load_pulse(ST_REQ_PULSE);
            ST_INIT_WAIT:
            begin
                // The command wait has run; clear adds its own wait before moving on.
                if (extra_pending)
                begin
                    extra_pending = 1'b0;
                    wait_left = lcd_regs[REG_CLEAR_WAIT];
                end
                else if (byte_held == CMD_FUNCTION_SET)
                    load_byte(ST_INIT_PULSE, CMD_DISPLAY_ON, 1'b0, 1'b0);
                else if (byte_held == CMD_DISPLAY_ON)
                    load_byte(ST_INIT_PULSE, CMD_ENTRY_MODE, 1'b0, 1'b0);
                else if (byte_held == CMD_ENTRY_MODE)
                    load_byte(ST_INIT_PULSE, CMD_CLEAR, 1'b0, 1'b1);
                else
                    seq_now = ST_IDLE;
            end
            ST_REQ_WAIT:
            begin
                if (extra_pending)
                begin
                    extra_pending = 1'b0;
                    wait_left = lcd_regs[REG_CLEAR_WAIT];
                end
                else
                begin
                    seq_now = ST_IDLE;
                end
            end
            default:
            begin
                seq_now = ST_IDLE;
                en_q = 1'b0;
            end
        endcase
    endfunction

    function automatic res_t predict_tick(input logic [2:0] rq, input logic [7:0] b,
                                          input logic [6:0] col, input logic [2:0] rw);
        res_t       pins;
        logic       took;
        logic [7:0] base;
        took = 1'b0;
        base = LINE_BASE_0;
        // Zero-length waits chain through several phases within the same tick.
        while (seq_now != ST_IDLE && wait_left == 16'd0)
            advance_seq();
        if (seq_now == ST_IDLE && rq >= REQ_COMMAND && rq <= REQ_CURSOR)
        begin
            took = 1'b1;
            case (rq)
                REQ_COMMAND: load_byte(ST_REQ_PULSE, b, 1'b0, 1'b0);
                REQ_DATA:    load_byte(ST_REQ_PULSE, b, 1'b1, 1'b0);
                REQ_CLEAR:   load_byte(ST_REQ_PULSE, CMD_CLEAR, 1'b0, 1'b1);
                REQ_HOME:    load_byte(ST_REQ_PULSE, CMD_HOME, 1'b0, 1'b1);
                default:
                begin
                    // Rows four and up are taken but send nothing.
                    if (rw < 3'd4)
                    begin
                        case (rw[1:0])
                            2'd0: base = LINE_BASE_0;
                            2'd1: base = LINE_BASE_1;
                            2'd2: base = LINE_BASE_2;
                            default: base = LINE_BASE_3;
                        endcase
                        load_byte(ST_REQ_PULSE, CMD_SET_DDRAM + base + {1'b0, col},
                                  1'b0, 1'b0);
                    end
                end
            endcase
        end
        if (seq_now != ST_IDLE && wait_left != 16'd0)
            wait_left = wait_left - 16'd1;
        pins.rs = rs_q;
        pins.enable = en_q;
        pins.data = nib_q;
        pins.busy = (seq_now != ST_IDLE);
        pins.accepted = took;
        return pins;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track_pins
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            lcd_regs[REG_ENABLE_TICKS] = RST_ENABLE_TICKS;
            lcd_regs[REG_DATA_WAIT] = RST_DATA_WAIT;
            lcd_regs[REG_COMMAND_WAIT] = RST_COMMAND_WAIT;
            lcd_regs[REG_CLEAR_WAIT] = RST_CLEAR_WAIT;
            lcd_regs[REG_POWER_UP_WAIT] = RST_POWER_UP_WAIT;
            lcd_regs[REG_RESET_LONG_WAIT] = RST_RESET_LONG_WAIT;
            lcd_regs[REG_RESET_SHORT_WAIT] = RST_RESET_SHORT_WAIT;
            seq_now = ST_START;
            wait_left = 16'd0;
            byte_held = 8'd0;
            low_next = 1'b0;
            extra_pending = 1'b0;
            rs_q = 1'b0;
            en_q = 1'b0;
            nib_q = 4'd0;
            expected_pins.delete();
            errors = 0;
            mismatch_count <= 0;
            pending_beats <= 0;
            busy_hint <= 1'b1;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_pins.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result beat with nothing expected", $time);
                end
                else
                begin
                    want = expected_pins.pop_front();
                    if (want.rs !== pin_rs || want.enable !== pin_enable ||
                        want.data !== pin_data || want.busy !== busy_res ||
                        want.accepted !== accepted)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"%0t: pin mismatch, expected rs=%0b e=%0b d=%h busy=%0b ",
                                      "acc=%0b, got rs=%0b e=%0b d=%h busy=%0b acc=%0b"},
                                     $time, want.rs, want.enable, want.data, want.busy,
                                     want.accepted, pin_rs, pin_enable, pin_data, busy_res,
                                     accepted);
                    end
                end
            end
            if (push && !full)
            begin
                got = predict_tick(req_type, byte_value, column, row);
                expected_pins.push_back(got);
                busy_hint <= got.busy;
            end
            if (cfg_write && cfg_index <= REG_RESET_SHORT_WAIT)
                lcd_regs[cfg_index] = cfg_data;
            mismatch_count <= errors;
            pending_beats <= expected_pins.size();
        end
    end

endmodule

// ----- sim/tb_char_lcd_4bit_interface_core.sv -----
`timescale 1ns / 1ps

module tb_char_lcd_4bit_interface_core;
    import clcd_pkg::*;

    localparam int         STALL_LIMIT        = 5000;
    localparam int         RANDOM_ITEMS       = 1200;
    localparam int         ITEMS_PER_SETTING  = 250;
    localparam logic [2:0] REQ_UNDEF_LO       = 3'd6;
    localparam logic [2:0] REQ_UNDEF_HI       = 3'd7;
    localparam logic [2:0] CFG_UNMAPPED_INDEX = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    logic [2:0]             req_type = REQ_TICK;
    logic [7:0]             byte_value = 8'd0;
    logic [6:0]             column = 7'd0;
    logic [2:0]             row = 3'd0;
    logic                   pop = 1'b0;
    logic                   empty;
    logic                   pin_rs;
    logic                   pin_enable;
    logic [3:0]             pin_data;
    logic                   busy_res;
    logic                   accepted;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_ENABLE_TICKS;
    logic [CFG_DATA_W-1:0]  cfg_data = 16'd0;

    int   mismatch_count;
    int   pending_beats;
    logic busy_hint;
    int   tx_idle_pct = 33;
    int   rx_idle_pct = 71;
    int   stall_cycles = 0;

    always #6 clk = ~clk;

    char_lcd_4bit_interface_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .req_type   (req_type),
        .byte_value (byte_value),
        .column     (column),
        .row        (row),
        .pop        (pop),
        .empty      (empty),
        .pin_rs     (pin_rs),
        .pin_enable (pin_enable),
        .pin_data   (pin_data),
        .busy_res   (busy_res),
        .accepted   (accepted),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    lcd_pin_checker u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .req_type       (req_type),
        .byte_value     (byte_value),
        .column         (column),
        .row            (row),
        .pop            (pop),
        .empty          (empty),
        .pin_rs         (pin_rs),
        .pin_enable     (pin_enable),
        .pin_data       (pin_data),
        .busy_res       (busy_res),
        .accepted       (accepted),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats),
        .busy_hint      (busy_hint)
    );

    always @(posedge clk)
        pop <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    task automatic send_item(input logic [2:0] rq, input logic [7:0] b,
                             input logic [6:0] col, input logic [2:0] rw);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req_type <= rq;
        byte_value <= b;
        column <= col;
        row <= rw;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_req(input logic [2:0] rq);
        send_item(rq, 8'($urandom_range(255)), 7'($urandom_range(127)),
                  3'($urandom_range(7)));
    endtask

    // The busy hint trails by one beat, so at least one tick always goes first.
    task automatic run_until_idle();
        send_req(REQ_TICK);
        while (busy_hint)
            send_req(REQ_TICK);
    endtask

    task automatic settle_results();
        push <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] en, input logic [15:0] dw,
                                input logic [15:0] cw, input logic [15:0] clw,
                                input logic [15:0] pw, input logic [15:0] lw,
                                input logic [15:0] sw);
        write_reg(REG_ENABLE_TICKS, en);
        write_reg(REG_DATA_WAIT, dw);
        write_reg(REG_COMMAND_WAIT, cw);
        write_reg(REG_CLEAR_WAIT, clw);
        write_reg(REG_POWER_UP_WAIT, pw);
        write_reg(REG_RESET_LONG_WAIT, lw);
        write_reg(REG_RESET_SHORT_WAIT, sw);
        write_reg(CFG_UNMAPPED_INDEX, 16'($urandom_range(65535)));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int          roll;
        logic [2:0]  rq;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short power-up script with zero-length waits and a zero enable width.
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd3, 16'd0, 16'd2);

        // Requests during the script are turned away.
        send_item(REQ_COMMAND, 8'h55, 7'd0, 3'd0);
        send_item(REQ_UNDEF_LO, 8'hAA, 7'h7F, 3'd7);
        send_item(REQ_UNDEF_HI, 8'h0F, 7'h2A, 3'd5);
        run_until_idle();
        send_item(REQ_COMMAND, 8'h00, 7'd0, 3'd0);
        run_until_idle();
        send_item(REQ_COMMAND, 8'hFF, 7'h7F, 3'd7);
        run_until_idle();
        send_item(REQ_DATA, 8'h00, 7'd0, 3'd0);
        send_item(REQ_DATA, 8'hA5, 7'd0, 3'd0);
        run_until_idle();
        send_item(REQ_DATA, 8'hFF, 7'h7F, 3'd7);
        run_until_idle();
        send_item(REQ_CLEAR, 8'h33, 7'd1, 3'd1);
        run_until_idle();
        send_item(REQ_HOME, 8'hC3, 7'd2, 3'd2);
        run_until_idle();
        send_item(REQ_CURSOR, 8'h00, 7'd0, 3'd0);
        run_until_idle();
        send_item(REQ_CURSOR, 8'hFF, 7'h7F, 3'd3);
        run_until_idle();
        send_item(REQ_CURSOR, 8'h12, 7'h40, 3'd1);
        run_until_idle();
        send_item(REQ_CURSOR, 8'h34, 7'h15, 3'd2);
        run_until_idle();
        // A bad row is taken and leaves the block idle for the very next request.
        send_item(REQ_CURSOR, 8'h56, 7'h11, 3'd4);
        send_item(REQ_CURSOR, 8'h78, 7'h22, 3'd7);
        send_item(REQ_UNDEF_LO, 8'h9A, 7'h33, 3'd0);
        send_item(REQ_UNDEF_HI, 8'hBC, 7'h44, 3'd1);
        send_item(REQ_TICK, 8'hDE, 7'h55, 3'd2);
        settle_results();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 71;
                rx_idle_pct = 33;
            end
            if (n == 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (n % ITEMS_PER_SETTING == 0)
            begin
                settle_results();
                program_regs(16'($urandom_range(4)), 16'($urandom_range(12)),
                             16'($urandom_range(12)), 16'($urandom_range(30)),
                             16'($urandom_range(65535)), 16'($urandom_range(65535)),
                             16'($urandom_range(65535)));
            end
            roll = $urandom_range(99);
            if (!busy_hint)
            begin
                if (roll < 80)
                    rq = 3'($urandom_range(REQ_CURSOR, REQ_COMMAND));
                else if (roll < 90)
                    rq = REQ_TICK;
                else
                    rq = 3'($urandom_range(REQ_UNDEF_HI, REQ_UNDEF_LO));
            end
            else
            begin
                if (roll < 85)
                    rq = REQ_TICK;
                else if (roll < 95)
                    rq = 3'($urandom_range(REQ_CURSOR, REQ_COMMAND));
                else
                    rq = 3'($urandom_range(REQ_UNDEF_HI, REQ_UNDEF_LO));
            end
            send_req(rq);
        end
        settle_results();

        // Longer enable pulse and longer command and clear waits on one clear beat.
        program_regs(16'd40, 16'd3, 16'd50, 16'd70, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(REQ_CLEAR, 8'h00, 7'd0, 3'd0);
        run_until_idle();
        settle_results();
        program_regs(16'd1, 16'd90, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(REQ_DATA, 8'h5A, 7'd0, 3'd0);
        run_until_idle();
        settle_results();

        if (mismatch_count == 0 && pending_beats == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
